// ===== src/lineb_pkg.sv =====
// Shared constants, types and state encoding for the line edit buffer.
`timescale 1ns / 1ps
package lineb_pkg;

  localparam int LINE_MAX = 64;
  localparam int ADDR_W   = $clog2(LINE_MAX);
  localparam int POS_W    = 6;
  localparam int CHAR_W   = 8;
  localparam int CMD_W    = 3;

  localparam logic [POS_W-1:0] LEN_LIMIT = POS_W'(LINE_MAX - 1);

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 3'd0,
    CMD_DELETE = 3'd1,
    CMD_SETCUR = 3'd2,
    CMD_READ   = 3'd3,
    CMD_CLEAR  = 3'd4,
    CMD_COMMIT = 3'd5
  } cmd_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_SHIFT,
    S_INS_PUT,
    S_DEL_SHIFT,
    S_RD_WAIT,
    S_CMT_RD,
    S_CMT_EMIT,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [CHAR_W-1:0] wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
  } mem_req_t;

  typedef struct packed {
    logic [CHAR_W-1:0] char_out;
    logic              char_valid;
    logic              accepted;
    logic [POS_W-1:0]  cursor_now;
    logic [POS_W-1:0]  length_now;
    logic              last;
  } res_t;

endpackage

// ===== src/line_edit_buffer.sv =====
// Line edit buffer top level: sequencer, line store and output register.
`timescale 1ns / 1ps
// Holds one text line of up to 63 bytes in a single-port-write, registered-read
// store, with a length and a cursor. One command word is taken at a time; the
// next is taken once every result word of the current one has moved into the
// output register, which may still be waiting on out_ready. Insert and delete
// move the tail one entry per cycle through the store's one read and one write
// port. Commit gives one result word per byte: each byte is read from the store,
// then loaded into the output register once it has room. After reset the line
// is empty; store contents beyond the length are never shown.
module line_edit_buffer (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [lineb_pkg::CMD_W-1:0]  in_command,
  input  logic [lineb_pkg::CHAR_W-1:0] in_char_in,
  input  logic [lineb_pkg::POS_W-1:0]  in_position,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [lineb_pkg::CHAR_W-1:0] out_char_out,
  output logic                         out_char_valid,
  output logic                         out_accepted,
  output logic [lineb_pkg::POS_W-1:0]  out_cursor_now,
  output logic [lineb_pkg::POS_W-1:0]  out_length_now,
  output logic                         out_last
);
  import lineb_pkg::*;

  mem_req_t          mem_req;
  logic [CHAR_W-1:0] rd_data;
  logic              slot_free;
  logic              res_load;
  res_t              res;
  res_t              out_res;

  lineb_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_command  (in_command),
    .in_char_in  (in_char_in),
    .in_position (in_position),
    .mem_req     (mem_req),
    .rd_data     (rd_data),
    .slot_free   (slot_free),
    .res_load    (res_load),
    .res         (res)
  );

  lineb_mem u_mem (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  lineb_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (res_load),
    .res       (res),
    .slot_free (slot_free),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  assign out_char_out   = out_res.char_out;
  assign out_char_valid = out_res.char_valid;
  assign out_accepted   = out_res.accepted;
  assign out_cursor_now = out_res.cursor_now;
  assign out_length_now = out_res.length_now;
  assign out_last       = out_res.last;

endmodule

// ===== src/lineb_mem.sv =====
// Line store: one write port, one registered read port.
`timescale 1ns / 1ps
module lineb_mem (
  input  logic                       clk,
  input  lineb_pkg::mem_req_t        req,
  output logic [lineb_pkg::CHAR_W-1:0] rd_data
);
  import lineb_pkg::*;

  logic [CHAR_W-1:0] store [LINE_MAX];
  logic [CHAR_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      store[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data_r <= store[req.rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== src/lineb_out.sv =====
// Output register stage for result words.
`timescale 1ns / 1ps
module lineb_out (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  lineb_pkg::res_t   res,
  output logic              slot_free,
  input  logic              out_ready,
  output logic              out_valid,
  output lineb_pkg::res_t   out_res
);
  import lineb_pkg::*;

  logic valid_r;
  res_t res_r;

  assign slot_free = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

// ===== src/lineb_ctrl.sv =====
// Command sequencer: length, cursor, shift passes and commit readout.
`timescale 1ns / 1ps
module lineb_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [lineb_pkg::CMD_W-1:0] in_command,
  input  logic [lineb_pkg::CHAR_W-1:0] in_char_in,
  input  logic [lineb_pkg::POS_W-1:0] in_position,
  output lineb_pkg::mem_req_t         mem_req,
  input  logic [lineb_pkg::CHAR_W-1:0] rd_data,
  input  logic                        slot_free,
  output logic                        res_load,
  output lineb_pkg::res_t             res
);
  import lineb_pkg::*;

  state_t            state_r, state_nxt;
  logic [POS_W-1:0]  len_r, len_nxt;
  logic [POS_W-1:0]  cur_r, cur_nxt;
  logic [POS_W-1:0]  idx_r, idx_nxt;
  logic [POS_W-1:0]  cnt_r, cnt_nxt;
  logic              pend_r, pend_nxt;
  logic [POS_W-1:0]  pend_addr_r, pend_addr_nxt;
  logic [CHAR_W-1:0] ch_r, ch_nxt;
  logic [CHAR_W-1:0] res_char_r, res_char_nxt;
  logic              res_valid_r, res_valid_nxt;
  logic              res_acc_r, res_acc_nxt;
  logic              accept;
  logic              cmt_final;
  logic [POS_W-1:0]  idx_inc;
  logic [POS_W-1:0]  idx_dec;

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign idx_inc   = idx_r + POS_W'(1);
  assign idx_dec   = idx_r - POS_W'(1);
  assign cmt_final = (idx_inc == cnt_r);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (in_command)
            CMD_INSERT: state_nxt = (len_r < LEN_LIMIT) ? S_INS_SHIFT : S_EMIT;
            CMD_DELETE: state_nxt = (cur_r != '0) ? S_DEL_SHIFT : S_EMIT;
            CMD_READ:   state_nxt = (cur_r < len_r) ? S_RD_WAIT : S_EMIT;
            CMD_COMMIT: state_nxt = (len_r != '0) ? S_CMT_RD : S_EMIT;
            default:    state_nxt = S_EMIT;
          endcase
        end
      end
      S_INS_SHIFT: state_nxt = (idx_r == cur_r) ? S_INS_PUT : S_INS_SHIFT;
      S_INS_PUT:   state_nxt = S_EMIT;
      S_DEL_SHIFT: state_nxt = (idx_r < len_r) ? S_DEL_SHIFT : S_EMIT;
      S_RD_WAIT:   state_nxt = S_EMIT;
      S_CMT_RD:    state_nxt = S_CMT_EMIT;
      S_CMT_EMIT: begin
        if (slot_free) begin
          state_nxt = cmt_final ? S_IDLE : S_CMT_RD;
        end
      end
      S_EMIT:      state_nxt = slot_free ? S_IDLE : S_EMIT;
      default:     state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    len_nxt       = len_r;
    cur_nxt       = cur_r;
    idx_nxt       = idx_r;
    cnt_nxt       = cnt_r;
    pend_nxt      = pend_r;
    pend_addr_nxt = pend_addr_r;
    ch_nxt        = ch_r;
    res_char_nxt  = res_char_r;
    res_valid_nxt = res_valid_r;
    res_acc_nxt   = res_acc_r;
    mem_req       = '0;
    res_load      = 1'b0;
    res           = '0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          res_char_nxt  = '0;
          res_valid_nxt = 1'b0;
          res_acc_nxt   = 1'b0;
          pend_nxt      = 1'b0;
          ch_nxt        = in_char_in;
          unique case (in_command)
            CMD_INSERT: idx_nxt = len_r;
            CMD_DELETE: idx_nxt = cur_r;
            CMD_SETCUR: cur_nxt = (in_position > len_r) ? len_r : in_position;
            CMD_READ: begin
              mem_req.rd_en   = (cur_r < len_r);
              mem_req.rd_addr = cur_r[ADDR_W-1:0];
            end
            CMD_CLEAR: begin
              len_nxt = '0;
              cur_nxt = '0;
            end
            CMD_COMMIT: begin
              cnt_nxt = len_r;
              idx_nxt = '0;
              len_nxt = '0;
              cur_nxt = '0;
            end
            default: ;
          endcase
        end
      end
      S_INS_SHIFT: begin
        mem_req.wr_en   = pend_r;
        mem_req.wr_addr = pend_addr_r[ADDR_W-1:0];
        mem_req.wr_data = rd_data;
        if (idx_r != cur_r) begin
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = idx_dec[ADDR_W-1:0];
          pend_nxt        = 1'b1;
          pend_addr_nxt   = idx_r;
          idx_nxt         = idx_dec;
        end else begin
          pend_nxt = 1'b0;
        end
      end
      S_INS_PUT: begin
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = cur_r[ADDR_W-1:0];
        mem_req.wr_data = ch_r;
        len_nxt         = len_r + POS_W'(1);
        cur_nxt         = cur_r + POS_W'(1);
        res_acc_nxt     = 1'b1;
      end
      S_DEL_SHIFT: begin
        mem_req.wr_en   = pend_r;
        mem_req.wr_addr = pend_addr_r[ADDR_W-1:0];
        mem_req.wr_data = rd_data;
        if (idx_r < len_r) begin
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = idx_r[ADDR_W-1:0];
          pend_nxt        = 1'b1;
          pend_addr_nxt   = idx_dec;
          idx_nxt         = idx_inc;
        end else begin
          pend_nxt    = 1'b0;
          len_nxt     = len_r - POS_W'(1);
          cur_nxt     = cur_r - POS_W'(1);
          res_acc_nxt = 1'b1;
        end
      end
      S_RD_WAIT: begin
        res_char_nxt  = rd_data;
        res_valid_nxt = 1'b1;
      end
      S_CMT_RD: begin
        mem_req.rd_en   = 1'b1;
        mem_req.rd_addr = idx_r[ADDR_W-1:0];
      end
      S_CMT_EMIT: begin
        res_load = slot_free;
        res      = '{char_out: rd_data, char_valid: 1'b1, accepted: 1'b0,
                     cursor_now: cur_r, length_now: len_r, last: cmt_final};
        if (slot_free) begin
          idx_nxt = idx_inc;
        end
      end
      S_EMIT: begin
        res_load = slot_free;
        res      = '{char_out: res_char_r, char_valid: res_valid_r,
                     accepted: res_acc_r, cursor_now: cur_r, length_now: len_r,
                     last: 1'b1};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      len_r   <= '0;
      cur_r   <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      len_r   <= len_nxt;
      cur_r   <= cur_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r       <= idx_nxt;
    cnt_r       <= cnt_nxt;
    pend_addr_r <= pend_addr_nxt;
    ch_r        <= ch_nxt;
    res_char_r  <= res_char_nxt;
    res_valid_r <= res_valid_nxt;
    res_acc_r   <= res_acc_nxt;
  end

endmodule

// ===== src/lineb_checker.sv =====
// Port-level checks for the line edit buffer, bound to the top level.
`timescale 1ns / 1ps
module lineb_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [lineb_pkg::CHAR_W-1:0] out_char_out,
  input logic                         out_char_valid,
  input logic                         out_accepted,
  input logic [lineb_pkg::POS_W-1:0]  out_cursor_now,
  input logic [lineb_pkg::POS_W-1:0]  out_length_now,
  input logic                         out_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_char_out) && $stable(out_last))
    else $error("result word changed while stalled");

  a_cursor_in_line: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_cursor_now <= out_length_now)
    else $error("cursor beyond line length");

  a_commit_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> out_char_valid && out_cursor_now == '0
                               && out_length_now == '0)
    else $error("commit run word malformed");

  a_char_not_edit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_char_valid |-> !out_accepted)
    else $error("byte word flagged as line change");

endmodule

bind line_edit_buffer lineb_checker u_lineb_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_char_out   (out_char_out),
  .out_char_valid (out_char_valid),
  .out_accepted   (out_accepted),
  .out_cursor_now (out_cursor_now),
  .out_length_now (out_length_now),
  .out_last       (out_last)
);
